// ===== sv/trsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsc_pkg
// Shared types, register codes and colour tables for the typing-rate core.
// ----------------------------------------------------------------------------
package trsc_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int CFG_W    = 16;
  localparam int CFG_IDXW = 3;

  localparam logic [CFG_IDXW-1:0] CFG_WINDOW   = 3'd0;
  localparam logic [CFG_IDXW-1:0] CFG_MIN_KEYS = 3'd1;
  localparam logic [CFG_IDXW-1:0] CFG_MIN_SPAN = 3'd2;
  localparam logic [CFG_IDXW-1:0] CFG_SLOW     = 3'd3;
  localparam logic [CFG_IDXW-1:0] CFG_MID      = 3'd4;
  localparam logic [CFG_IDXW-1:0] CFG_FAST     = 3'd5;

  localparam logic [15:0] WINDOW_RST   = 16'd5000;
  localparam logic [4:0]  MIN_KEYS_RST = 5'd3;
  localparam logic [15:0] MIN_SPAN_RST = 16'd500;
  localparam logic [7:0]  SLOW_RST     = 8'd20;
  localparam logic [7:0]  MID_RST      = 8'd40;
  localparam logic [7:0]  FAST_RST     = 8'd60;

  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [2:0]  LAYER_MAX  = 3'd4;

  localparam logic [7:0] HUE_BOTH   = 8'd215;
  localparam logic [7:0] HUE_CAPS   = 8'd0;
  localparam logic [7:0] HUE_NUM    = 8'd170;
  localparam logic [7:0] HUE_GREEN  = 8'd85;
  localparam logic [7:0] HUE_YELLOW = 8'd43;
  localparam logic [7:0] HUE_ORANGE = 8'd21;
  localparam logic [7:0] HUE_RED    = 8'd0;
  localparam logic [7:0] FULL       = 8'd255;

  typedef enum logic [1:0] {
    ACT_PRESS = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_LAYER = 2'd2,
    ACT_LOCK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic scan_rd;
    logic mul;
    logic eval;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic early;
    logic div_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic       drive;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
  } colour_t;

  function automatic colour_t layer_colour(input logic [2:0] layer);
    colour_t c;
    c.drive = 1'b1;
    c.sat   = FULL;
    c.bri   = FULL;
    case (layer)
      3'd1:    c.hue = 8'd128;
      3'd2:    c.hue = 8'd28;
      3'd3:    c.hue = 8'd85;
      3'd4:    c.hue = 8'd191;
      default: begin
        c.hue = 8'd0;
        c.sat = 8'd0;
      end
    endcase
    return c;
  endfunction

  // Priority: both locks, caps, num, layer, then rate band.
  function automatic colour_t pick_colour(
    input logic       caps,
    input logic       num,
    input logic [7:0] rate,
    input logic [2:0] layer,
    input logic [7:0] slow,
    input logic [7:0] mid,
    input logic [7:0] fast
  );
    colour_t c;
    c.drive = 1'b1;
    c.hue   = 8'd0;
    c.sat   = FULL;
    c.bri   = FULL;
    if (!caps && !num && rate == 8'd0 && layer == 3'd0) begin
      c = '0;
    end else if (caps && num) begin
      c.hue = HUE_BOTH;
    end else if (caps) begin
      c.hue = HUE_CAPS;
    end else if (num) begin
      c.hue = HUE_NUM;
    end else if (layer != 3'd0) begin
      c = layer_colour(layer);
    end else if (rate < slow) begin
      c.hue = HUE_GREEN;
    end else if (rate < mid) begin
      c.hue = HUE_YELLOW;
    end else if (rate < fast) begin
      c.hue = HUE_ORANGE;
    end else begin
      c.hue = HUE_RED;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/trsc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsc_ctrl
// Sequencer: accept, ring scan, multiply, evaluate, serial divide, deliver.
// ----------------------------------------------------------------------------
module trsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_action,
  output trsc_pkg::cmd_t         cmd,
  input  trsc_pkg::sts_t         sts,
  output logic                   in_ready
);
  import trsc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_PRESS || in_action == ACT_TICK) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN:  if (sts.scan_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_MUL;
      S_MUL:   state_next = S_EVAL;
      S_EVAL:  state_next = sts.early ? S_DONE : S_DIV;
      S_DIV:   if (sts.div_last) state_next = S_DONE;
      S_DONE:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_SCAN:  cmd.scan_rd  = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_EVAL:  cmd.eval     = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_DONE:  cmd.fin      = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/trsc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trsc_datapath
// Press ring, window scan, rate divider, status registers and output beat.
// ----------------------------------------------------------------------------
module trsc_datapath #(
  parameter int RING_DEPTH = trsc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [trsc_pkg::CFG_IDXW-1:0] cfg_index,
  input  wire logic [trsc_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [1:0]                    in_action,
  input  wire logic [31:0]                   in_now,
  input  wire logic [2:0]                    in_layer,
  input  wire logic                          in_caps,
  input  wire logic                          in_num,
  input  trsc_pkg::cmd_t                     cmd,
  output trsc_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output trsc_pkg::colour_t                  out_colour,
  output logic [7:0]                         out_rate
);
  import trsc_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int PW = CW + 16;

  // configuration
  logic [15:0] window_ms, min_span_ms;
  logic [4:0]  min_keys;
  logic [7:0]  slow_limit, mid_limit, fast_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= WINDOW_RST;
      min_keys    <= MIN_KEYS_RST;
      min_span_ms <= MIN_SPAN_RST;
      slow_limit  <= SLOW_RST;
      mid_limit   <= MID_RST;
      fast_limit  <= FAST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW:   window_ms   <= cfg_data;
        CFG_MIN_KEYS: min_keys    <= cfg_data[4:0];
        CFG_MIN_SPAN: min_span_ms <= cfg_data;
        CFG_SLOW:     slow_limit  <= cfg_data[7:0];
        CFG_MID:      mid_limit   <= cfg_data[7:0];
        CFG_FAST:     fast_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]  act;
  logic [31:0] now_r;
  logic [2:0]  layer_r;
  logic        caps_r, num_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act     <= in_action;
      now_r   <= in_now;
      layer_r <= (in_layer > LAYER_MAX) ? LAYER_MAX : in_layer;
      caps_r  <= in_caps;
      num_r   <= in_num;
    end
  end

  // press ring: stored stamps in memory, occupancy in flip-flops
  logic [31:0]           ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] used;
  logic [AW-1:0]         slot, raddr;
  logic [31:0]           rdata;
  logic                  rused, pend;
  logic                  do_write;

  assign do_write = cmd.latch && (in_action == ACT_PRESS);

  always_ff @(posedge clk) begin
    if (do_write) ring[slot] <= in_now;
    if (cmd.scan_rd) rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      slot  <= '0;
      raddr <= '0;
      pend  <= 1'b0;
      rused <= 1'b0;
    end else begin
      if (do_write) begin
        used[slot] <= (in_now != 32'd0);
        slot <= (slot == AW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
      end
      pend <= cmd.scan_rd;
      if (cmd.scan_rd) rused <= used[raddr];
      if (cmd.latch) begin
        raddr <= '0;
      end else if (cmd.scan_rd) begin
        raddr <= raddr + 1'b1;
      end
    end
  end

  assign sts.scan_last = (raddr == AW'(RING_DEPTH - 1));

  // window accumulation, one slot a cycle
  logic [CW-1:0] count;
  logic [31:0]   oldest, age;

  assign age = now_r - rdata;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      count  <= '0;
      oldest <= in_now;
    end else if (pend && rused && (age < {16'd0, window_ms})) begin
      count <= count + 1'b1;
      if (rdata < oldest) oldest <= rdata;
    end
  end

  // multiply, then decide early out or divide
  logic [PW-1:0] prod;
  logic [31:0]   span;
  logic          zero_c, sat_c, zero_r, sat_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'(count) * PW'(MS_PER_MIN);
      span <= now_r - oldest;
    end
  end

  assign zero_c = ({{(8 - CW){1'b0}}, count} < {3'd0, min_keys})
               || (span < {16'd0, min_span_ms}) || (span == 32'd0);
  assign sat_c  = ({{(40 - PW){1'b0}}, prod} >= {span, 8'd0});
  assign sts.early = zero_c || sat_c;

  // restoring divide for the eight quotient bits left below saturation
  logic [31:0] rem;
  logic [7:0]  dlow, quot;
  logic [2:0]  dcnt;
  logic [32:0] r2;
  logic        ge;

  assign r2 = {rem, dlow[7]};
  assign ge = (r2 >= {1'b0, span});
  assign sts.div_last = (dcnt == 3'd7);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      zero_r <= zero_c;
      sat_r  <= sat_c;
      rem    <= {{(40 - PW){1'b0}}, prod[PW-1:8]};
      dlow   <= prod[7:0];
      quot   <= '0;
      dcnt   <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? 32'(r2 - {1'b0, span}) : r2[31:0];
      dlow <= {dlow[6:0], 1'b0};
      quot <= {quot[6:0], ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  // status update and colour pick
  logic [7:0] stored_rate;
  logic [2:0] stored_layer;
  logic       caps_flag, num_flag;
  logic [7:0] rate_res, rate_new;
  logic [2:0] layer_new;
  logic       caps_new, num_new, redraw;
  colour_t    pick;

  always_comb begin
    rate_res  = zero_r ? 8'd0 : (sat_r ? FULL : quot);
    rate_new  = stored_rate;
    layer_new = stored_layer;
    caps_new  = caps_flag;
    num_new   = num_flag;
    redraw    = 1'b1;
    case (act)
      ACT_PRESS: rate_new = rate_res;
      ACT_TICK: begin
        rate_new = rate_res;
        redraw   = (rate_res != stored_rate);
      end
      ACT_LAYER: layer_new = layer_r;
      ACT_LOCK: begin
        caps_new = caps_r;
        num_new  = num_r;
      end
      default: redraw = 1'b1;
    endcase
    pick = pick_colour(caps_new, num_new, rate_new, layer_new,
                       slow_limit, mid_limit, fast_limit);
    if (!redraw) pick = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_rate  <= '0;
      stored_layer <= '0;
      caps_flag    <= 1'b0;
      num_flag     <= 1'b0;
    end else if (cmd.fin) begin
      stored_rate  <= rate_new;
      stored_layer <= layer_new;
      caps_flag    <= caps_new;
      num_flag     <= num_new;
    end
  end

  // output beat register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_colour <= pick;
      out_rate   <= rate_new;
    end
  end

endmodule
`default_nettype wire

// ===== sv/typing_rate_status_color_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// typing_rate_status_color_core
// Typing-rate meter and status colour picker for a five-LED strip.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one event: a key press, a rate tick, a layer change
//   or a lock change (action in s_axis_tuser). Every event yields exactly one
//   output beat with the strip colour and the current rate in m_axis_tdata
//   and the drive flag in m_axis_tuser.
//   Presses and ticks scan the whole press ring, one slot a cycle through the
//   single memory read port, then run an 8-step serial divide unless the
//   rate is zero or saturated. One event is in flight at a time;
//   s_axis_tready is high only while the sequencer is idle.
//   The finished beat sits in an output register, so the next event is
//   taken while the receiver stalls; a second result then waits in the
//   sequencer until the register frees.
//   Reset clears the ring occupancy bits at once (no clearing pass), the
//   stored rate, layer and locks, and loads the register defaults.
//   Configuration writes (cfg_we/cfg_index/cfg_data) belong in idle time.
// ----------------------------------------------------------------------------
module typing_rate_status_color_core #(
  parameter int RING_DEPTH = trsc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [trsc_pkg::CFG_IDXW-1:0] cfg_index,
  input  wire logic [trsc_pkg::CFG_W-1:0]    cfg_data,
  // event stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] now_ms, [34:32] layer_index, [35] caps_on, [36] num_on, [39:37] zero
  input  wire logic [39:0]                   s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]                    s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] hue, [15:8] saturation, [23:16] brightness, [31:24] rate_wpm
  output logic [31:0]                        m_axis_tdata,
  // [0] drive
  output logic                               m_axis_tuser
);
  import trsc_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  colour_t colour;
  logic [7:0] rate;

  // Sequencer: owns the input handshake and steps the datapath.
  trsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .in_ready  (s_axis_tready)
  );

  // Datapath: ring, scan, divider, status and the output beat register.
  trsc_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_action  (s_axis_tuser),
    .in_now     (s_axis_tdata[31:0]),
    .in_layer   (s_axis_tdata[34:32]),
    .in_caps    (s_axis_tdata[35]),
    .in_num     (s_axis_tdata[36]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_colour (colour),
    .out_rate   (rate)
  );

  // Pack the result beat, hue in the lowest byte and rate in the highest.
  assign m_axis_tdata = {rate, colour.bri, colour.sat, colour.hue};
  assign m_axis_tuser = colour.drive;

  // One event in flight: no accept in the cycle after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // An undriven result carries a blank colour.
  a_blank_undriven: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("colour present on an undriven result");

  // Output register empties on reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

// ===== tb/tb_typing_rate_status_color_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_typing_rate_status_color_core
// Self-checking bench for the typing-rate meter and strip colour picker.
// ----------------------------------------------------------------------------
// A short table of events covers the layer and lock colours, layers above
// four, a press at time zero, a saturated rate, an unchanged tick and a ring
// that straddles the 32-bit time wrap. Random phases follow, each with its
// own register settings (the extremes among them): mostly human-like press
// streams on a running clock, with ticks, layer and lock events mixed in,
// plus a share of raw random events. Every accepted event runs through a
// local rate meter and colour picker; each result beat is checked field by
// field against the oldest prediction. Both stream sides idle in random
// bursts, except in the final phase (and every third phase for the receiver).
// ----------------------------------------------------------------------------
module tb_typing_rate_status_color_core;
  import trsc_pkg::*;

  localparam int LIMIT       = 600000;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 108;
  localparam int DRAIN_WAIT  = 40;

  // Result of one event, as it appears on the result stream.
  typedef struct packed {
    logic       drive;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
    logic [7:0] rate;
  } strip_t;

  // One line of the opening table; want is only used when typed is set.
  typedef struct packed {
    action_t     act;
    logic [31:0] now;
    logic [2:0]  layer;
    logic        caps;
    logic        num;
    logic        typed;
    strip_t      want;
  } opening_row_t;

  localparam strip_t DARK = '0;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CFG_IDXW-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [31:0] now_ms, [34:32] layer_index, [35] caps_on, [36] num_on, [39:37] zero
  logic [39:0]         s_axis_tdata;
  // [1:0] action
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [7:0] hue, [15:8] saturation, [23:16] brightness, [31:24] rate_wpm
  logic [31:0]         m_axis_tdata;
  // [0] drive
  logic                m_axis_tuser;

  typing_rate_status_color_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the meter: press ring, status and register settings
  // --------------------------------------------------------------------------
  logic [31:0] press_log [RING_DEPTH_DEF];
  int          next_slot;
  logic [7:0]  meter_rate;
  logic [2:0]  shown_layer;
  logic        caps_lit;
  logic        num_lit;

  logic [15:0] cfg_window;
  logic [4:0]  cfg_min_keys;
  logic [15:0] cfg_min_span;
  logic [7:0]  cfg_slow;
  logic [7:0]  cfg_mid;
  logic [7:0]  cfg_fast;

  strip_t expected_strips [$];
  int     failures;
  int     cycles;
  bit     calm;      // no idling on either side
  bit     stall_on;  // receiver stalls allowed in this phase
  int     sink_hold;

  // Presses per minute over the live part of the ring. Slots holding zero
  // are empty; age uses wrapping 32-bit difference, the oldest press a plain
  // compare seeded with the current time.
  function automatic logic [7:0] rate_at(input logic [31:0] now);
    int unsigned count;
    logic [31:0] oldest;
    logic [31:0] age;
    logic [31:0] span;
    logic [63:0] quot;
    count  = 0;
    oldest = now;
    for (int i = 0; i < RING_DEPTH_DEF; i++) begin
      age = now - press_log[i];
      if (press_log[i] != 32'd0 && age < {16'd0, cfg_window}) begin
        count++;
        if (press_log[i] < oldest) oldest = press_log[i];
      end
    end
    if (count < cfg_min_keys) return 8'd0;
    span = now - oldest;
    if (span < {16'd0, cfg_min_span} || span == 32'd0) return 8'd0;
    quot = (64'(count) * 64'd60000) / 64'(span);
    return (quot > 64'd255) ? 8'd255 : quot[7:0];
  endfunction

  // Apply one event to the local meter and work out the strip it gives.
  task automatic meter_event(input action_t act, input logic [31:0] now,
                             input logic [2:0] layer, input logic caps,
                             input logic num, output strip_t res);
    logic [7:0] fresh;
    logic       paint;
    paint = 1'b1;
    case (act)
      ACT_PRESS: begin
        press_log[next_slot] = now;
        next_slot  = (next_slot + 1) % RING_DEPTH_DEF;
        meter_rate = rate_at(now);
      end
      ACT_TICK: begin
        // redraw only when the rate moved
        fresh      = rate_at(now);
        paint      = (fresh != meter_rate);
        meter_rate = fresh;
      end
      ACT_LAYER: begin
        shown_layer = (layer > LAYER_MAX) ? LAYER_MAX : layer;
      end
      default: begin
        caps_lit = caps;
        num_lit  = num;
      end
    endcase
    res      = DARK;
    res.rate = meter_rate;
    // idle on layer 0 with no lock and no rate: leave the strip alone
    if (paint && (caps_lit || num_lit || meter_rate != 8'd0 || shown_layer != 3'd0)) begin
      res.drive = 1'b1;
      res.sat   = FULL;
      res.bri   = FULL;
      if (caps_lit && num_lit) begin
        res.hue = HUE_BOTH;
      end else if (caps_lit) begin
        res.hue = HUE_CAPS;
      end else if (num_lit) begin
        res.hue = HUE_NUM;
      end else if (shown_layer != 3'd0) begin
        case (shown_layer)
          3'd1:    res.hue = 8'd128;
          3'd2:    res.hue = 8'd28;
          3'd3:    res.hue = 8'd85;
          default: res.hue = 8'd191;
        endcase
      end else if (meter_rate < cfg_slow) begin
        res.hue = HUE_GREEN;
      end else if (meter_rate < cfg_mid) begin
        res.hue = HUE_YELLOW;
      end else if (meter_rate < cfg_fast) begin
        res.hue = HUE_ORANGE;
      end else begin
        res.hue = HUE_RED;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Event side
  // --------------------------------------------------------------------------

  // Offer one event beat, holding it until taken; an optional idle burst
  // goes in front. Returns just after the accepting edge.
  task automatic send_event(input action_t act, input logic [31:0] now,
                            input logic [2:0] layer, input logic caps,
                            input logic num, input logic typed,
                            input strip_t want);
    strip_t predicted;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, num, caps, layer, now};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    meter_event(act, now, layer, caps, num, predicted);
    // table rows with a typed result check that instead of the prediction
    expected_strips.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold until every result beat is back; the block is idle
  // once the last one has been taken.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_strips.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] win, input logic [4:0] keys,
                               input logic [15:0] span, input logic [7:0] slow,
                               input logic [7:0] mid, input logic [7:0] fast);
    write_reg(CFG_WINDOW,   win);
    write_reg(CFG_MIN_KEYS, {11'd0, keys});
    write_reg(CFG_MIN_SPAN, span);
    write_reg(CFG_SLOW,     {8'd0, slow});
    write_reg(CFG_MID,      {8'd0, mid});
    write_reg(CFG_FAST,     {8'd0, fast});
    @(negedge clk);
    cfg_we       <= 1'b0;
    cfg_window   = win;
    cfg_min_keys = keys;
    cfg_min_span = span;
    cfg_slow     = slow;
    cfg_mid      = mid;
    cfg_fast     = fast;
  endtask

  function automatic strip_t lit(input logic [7:0] hue, input logic [7:0] rate);
    lit = '{drive: 1'b1, hue: hue, sat: FULL, bri: FULL, rate: rate};
  endfunction

  function automatic opening_row_t row(input action_t act, input logic [31:0] now,
                                       input logic [2:0] layer, input logic caps,
                                       input logic num, input logic typed,
                                       input strip_t want);
    row = '{act: act, now: now, layer: layer, caps: caps, num: num,
            typed: typed, want: want};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    opening_row_t opening [$];
    logic [31:0]  clock_ms;
    logic [31:0]  now;
    logic [31:0]  gap;
    action_t      act;
    int           pick;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_PRESS;
    calm          = 1'b0;
    stall_on      = 1'b1;
    failures      = 0;
    for (int i = 0; i < RING_DEPTH_DEF; i++) press_log[i] = 32'd0;
    next_slot    = 0;
    meter_rate   = 8'd0;
    shown_layer  = 3'd0;
    caps_lit     = 1'b0;
    num_lit      = 1'b0;
    cfg_window   = WINDOW_RST;
    cfg_min_keys = MIN_KEYS_RST;
    cfg_min_span = MIN_SPAN_RST;
    cfg_slow     = SLOW_RST;
    cfg_mid      = MID_RST;
    cfg_fast     = FAST_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Opening table, at the reset settings.
    // tick with an empty ring: rate stays zero, strip untouched
    opening.push_back(row(ACT_TICK,  32'd1000, 3'd0, 1'b0, 1'b0, 1'b1, DARK));
    opening.push_back(row(ACT_LAYER, 32'd1000, 3'd0, 1'b0, 1'b0, 1'b1, DARK));
    // layers above four show as layer four
    opening.push_back(row(ACT_LAYER, 32'd1010, 3'd7, 1'b0, 1'b0, 1'b1, lit(8'd191, 8'd0)));
    opening.push_back(row(ACT_LAYER, 32'd1020, 3'd5, 1'b0, 1'b0, 1'b1, lit(8'd191, 8'd0)));
    opening.push_back(row(ACT_LAYER, 32'd1030, 3'd1, 1'b0, 1'b0, 1'b1, lit(8'd128, 8'd0)));
    opening.push_back(row(ACT_LAYER, 32'd1040, 3'd2, 1'b0, 1'b0, 1'b1, lit(8'd28, 8'd0)));
    opening.push_back(row(ACT_LAYER, 32'd1050, 3'd3, 1'b0, 1'b0, 1'b1, lit(8'd85, 8'd0)));
    opening.push_back(row(ACT_LAYER, 32'd1060, 3'd4, 1'b0, 1'b0, 1'b1, lit(8'd191, 8'd0)));
    // locks outrank the layer colour
    opening.push_back(row(ACT_LOCK,  32'd1070, 3'd0, 1'b1, 1'b1, 1'b1, lit(HUE_BOTH, 8'd0)));
    opening.push_back(row(ACT_LOCK,  32'd1080, 3'd0, 1'b1, 1'b0, 1'b1, lit(HUE_CAPS, 8'd0)));
    opening.push_back(row(ACT_LOCK,  32'd1090, 3'd0, 1'b0, 1'b1, 1'b1, lit(HUE_NUM, 8'd0)));
    opening.push_back(row(ACT_LOCK,  32'd1100, 3'd0, 1'b0, 1'b0, 1'b1, lit(8'd191, 8'd0)));
    opening.push_back(row(ACT_LAYER, 32'd1110, 3'd0, 1'b0, 1'b0, 1'b1, DARK));
    // press at time zero lands in an empty-looking slot
    opening.push_back(row(ACT_PRESS, 32'd0,    3'd0, 1'b0, 1'b0, 1'b1, DARK));
    // build up a burst fast enough to saturate the rate
    opening.push_back(row(ACT_PRESS, 32'd1000, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_PRESS, 32'd1200, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_PRESS, 32'd1400, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_PRESS, 32'd1600, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    // unchanged rate on a tick: no redraw
    opening.push_back(row(ACT_TICK,  32'd1600, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_LOCK,  32'd1700, 3'd7, 1'b1, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_LOCK,  32'd1800, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    // everything aged out
    opening.push_back(row(ACT_TICK,  32'd40000, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    // presses across the time wrap
    opening.push_back(row(ACT_PRESS, 32'hFFFF_FF00, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_PRESS, 32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_PRESS, 32'h0000_0300, 3'd0, 1'b0, 1'b0, 1'b0, DARK));
    opening.push_back(row(ACT_TICK,  32'h0000_0400, 3'd0, 1'b0, 1'b0, 1'b0, DARK));

    foreach (opening[k]) begin
      send_event(opening[k].act, opening[k].now, opening[k].layer, opening[k].caps,
                 opening[k].num, opening[k].typed, opening[k].want);
    end

    // Random phases. Phase 0 keeps the reset settings, the next two go to the
    // low and high extremes and phase 3 to fixed settings; the rest are random.
    clock_ms = 32'd5000;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1:       load_settings(16'd1, 5'd1, 16'd0, 8'd0, 8'd0, 8'd0);
          2:       load_settings(16'hFFFF, 5'd16, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
          3:       load_settings(16'hFFFF, 5'd1, 16'd0, 8'd100, 8'd180, 8'd230);
          default: load_settings(16'($urandom_range(1500, 65535)),
                                 5'($urandom_range(1, 16)),
                                 16'($urandom_range(0, 3000)),
                                 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
        endcase
      end
      calm     = (ph == PHASES - 1);
      stall_on = (ph % 3 != 2);
      // now and then start just short of the time wrap
      if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 60000);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 99) < 75) begin
          // well-formed traffic on the running clock
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            act = ACT_PRESS;
            if ($urandom_range(0, 9) == 0) gap = 32'd0;
            else if ($urandom_range(0, 9) == 0) gap = $urandom_range(2000, 80000);
            else gap = $urandom_range(40, 700);
          end else begin
            act = (pick < 8) ? ACT_TICK : ((pick == 8) ? ACT_LAYER : ACT_LOCK);
            gap = $urandom_range(0, 2000);
          end
          clock_ms = clock_ms + gap;
          now      = clock_ms;
        end else begin
          // noise: any event at any time
          act = action_t'($urandom_range(0, 3));
          now = $urandom;
        end
        send_event(act, now, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'b0, DARK);
      end
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, then check each beat taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst || calm || !stall_on) begin
      m_axis_tready <= 1'b1;
      sink_hold     <= 0;
    end else if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      // start a stall burst; sink_hold holds how many more low cycles follow
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial m_axis_tready = 1'b1;

  always @(posedge clk) begin : check_strip
    strip_t want;
    strip_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.drive = m_axis_tuser;
      got.hue   = m_axis_tdata[7:0];
      got.sat   = m_axis_tdata[15:8];
      got.bri   = m_axis_tdata[23:16];
      got.rate  = m_axis_tdata[31:24];
      if (expected_strips.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        failures++;
      end else begin
        want = expected_strips.pop_front();
        if (got.drive !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, got.drive);
          failures++;
        end
        if (got.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, got.hue);
          failures++;
        end
        if (got.sat !== want.sat) begin
          $error("saturation: expected %0d, got %0d", want.sat, got.sat);
          failures++;
        end
        if (got.bri !== want.bri) begin
          $error("brightness: expected %0d, got %0d", want.bri, got.bri);
          failures++;
        end
        if (got.rate !== want.rate) begin
          $error("rate_wpm: expected %0d, got %0d", want.rate, got.rate);
          failures++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/trsc_pkg.sv
sv/trsc_ctrl.sv
sv/trsc_datapath.sv
sv/typing_rate_status_color_core.sv
tb/tb_typing_rate_status_color_core.sv
